// ----- hdl/pbr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared widths, reset values, register indexes and types of the pulse beat
// rate detector.
// ----------------------------------------------------------------------------
package pbr_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int TIME_W     = 32;
	localparam int RATE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_W      = 16;
	localparam int RATE_MAX   = 255;

	localparam int HISTORY_DEPTH_DEF = 10;

	localparam logic [SAMPLE_W-1:0]   HYST_RST     = 10'd100;
	localparam logic [CFG_DATA_W-1:0] MIN_INT_RST  = 16'd250;
	localparam logic [CFG_DATA_W-1:0] NO_FING_RST  = 16'd2000;
	localparam logic [CFG_DATA_W-1:0] INACT_RST    = 16'd10000;

	localparam logic [CFG_IDX_W-1:0] REG_HYST    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NO_FING = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INACT   = 2'd3;

	// Milliseconds per minute, the dividend of the rate division.
	localparam logic [DIV_W-1:0] RATE_NUM = 16'd60000;

	// Just above 4/5 * 2^16: floor(x * 52432 / 2^16) equals floor(4x / 5) for 10-bit x.
	localparam int THR_FRAC = 16;
	localparam int THR_W    = SAMPLE_W + THR_FRAC;
	localparam logic [THR_W-1:0] THR_RECIP = 26'd52432;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              clear;
		logic              write;
		logic              fill;
		logic [RATE_W-1:0] rate;
	} hist_cmd_t;

	// Four fifths of a swing, rounded down.
	function automatic logic [SAMPLE_W-1:0] swing_thr(input logic [SAMPLE_W-1:0] swing);
		logic [THR_W-1:0] prod;
		prod = THR_W'(swing) * THR_RECIP;
		return prod[THR_W-1:THR_FRAC];
	endfunction

endpackage

// ----- hdl/pbr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_in_if / pbr_out_if
// Valid/ready channels for sensor sample items and detector result items.
// ----------------------------------------------------------------------------
interface pbr_in_if;
	logic                          valid;
	logic                          ready;
	logic                          restart;
	logic [pbr_pkg::SAMPLE_W-1:0]  sample_value;
	logic [pbr_pkg::TIME_W-1:0]    sample_time;

	modport source(output valid, restart, sample_value, sample_time, input ready);
	modport sink(input valid, restart, sample_value, sample_time, output ready);
endinterface

interface pbr_out_if;
	logic                        valid;
	logic                        ready;
	logic                        beat;
	logic                        rise;
	logic                        phase_rising;
	logic [pbr_pkg::RATE_W-1:0]  instant_rate;
	logic [pbr_pkg::RATE_W-1:0]  average_rate;
	logic                        finger_present;
	logic                        inactive;

	modport source(output valid, beat, rise, phase_rising, instant_rate, average_rate,
		finger_present, inactive, input ready);
	modport sink(input valid, beat, rise, phase_rising, instant_rate, average_rate,
		finger_present, inactive, output ready);
endinterface

// ----- hdl/pbr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_div
// Restoring divider, one quotient bit per cycle, that computes the beat rate
// from the beat interval.
// ----------------------------------------------------------------------------
module pbr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pbr_pkg::div_req_t req,
	output pbr_pkg::div_rsp_t rsp
);

	localparam int DW   = pbr_pkg::DIV_W;
	localparam int TW   = pbr_pkg::TIME_W;
	localparam int CntW = $clog2(DW + 1);

	logic [TW-1:0]   rem_q;
	logic [TW-1:0]   dsr_q;
	logic [DW-1:0]   dvd_q;
	logic [DW-1:0]   quo_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [TW:0] trial;
	logic [TW:0] diff;
	logic        ge;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsr_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == CntW'(1));
			if (req.start) begin
				rem_q  <= '0;
				dsr_q  <= req.divisor;
				dvd_q  <= req.dividend;
				quo_q  <= '0;
				cnt_q  <= CntW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// The partial remainder stays below the divisor, so it fits in TW bits.
				rem_q <= ge ? diff[TW-1:0] : trial[TW-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
				quo_q <= {quo_q[DW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- hdl/pbr_history.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_history
// Rate history ring with write pointer and a running sum of its entries.
// ----------------------------------------------------------------------------
module pbr_history #(
	parameter int HISTORY_DEPTH = pbr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  pbr_pkg::hist_cmd_t                               cmd,
	output logic [$clog2(HISTORY_DEPTH*pbr_pkg::RATE_MAX+1)-1:0] sum
);

	localparam int SumW = $clog2(HISTORY_DEPTH * pbr_pkg::RATE_MAX + 1);
	localparam int PosW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int RW   = pbr_pkg::RATE_W;

	logic [RW-1:0]   hist_q [HISTORY_DEPTH];
	logic [PosW-1:0] pos_q;
	logic [SumW-1:0] sum_q;

	logic [RW-1:0] old_entry;

	assign old_entry = hist_q[pos_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			pos_q <= '0;
			sum_q <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			pos_q <= '0;
			sum_q <= '0;
		end else if (cmd.write) begin
			if (cmd.fill) begin
				// First beat after finger loss seeds every entry.
				for (int i = 0; i < HISTORY_DEPTH; i++) begin
					hist_q[i] <= cmd.rate;
				end
				sum_q <= SumW'(cmd.rate) * SumW'(HISTORY_DEPTH);
			end else begin
				hist_q[pos_q] <= cmd.rate;
				sum_q         <= sum_q - SumW'(old_entry) + SumW'(cmd.rate);
			end
			if (pos_q == PosW'(HISTORY_DEPTH - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	assign sum = sum_q;

endmodule

// ----- hdl/pulse_beat_rate_detector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_beat_rate_detector_core
// Hysteresis peak/trough tracker of a pulse sensor with beat rate averaging.
//
// Samples arrive as items on sample_in (valid/ready): restart, a 10-bit value
// and a millisecond timestamp. Each item produces exactly one result item on
// result_out with the beat and rise flags, the current phase, the latest and
// the averaged rate, finger presence and the inactivity flag.
// The user writes the four registers through cfg_we/cfg_index/cfg_wdata only
// while idle; the block itself does not enforce it. One item is processed at
// a time. An item without a beat is evaluated and its result is loaded in the
// check state; the next item is accepted once the block is back in idle. An
// accepted beat runs the one-bit-per-cycle divider for 60000/interval and then
// updates the history before its result is loaded. The history mean is a
// reciprocal multiplication of the running sum.
// The result sits in an output register, so a new item is accepted while the
// receiver stalls; the block waits only when a second result is ready and the
// first is still held.
// Reset sets the registers to their defaults, the phase to rising, the finger
// as present and clears the rate history; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pulse_beat_rate_detector_core #(
	parameter int HISTORY_DEPTH = pbr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pbr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	pbr_in_if.sink                           sample_in,
	pbr_out_if.source                        result_out
);

	localparam int SW   = pbr_pkg::SAMPLE_W;
	localparam int TW   = pbr_pkg::TIME_W;
	localparam int RW   = pbr_pkg::RATE_W;
	localparam int CW   = pbr_pkg::CFG_DATA_W;
	localparam int DW   = pbr_pkg::DIV_W;
	localparam int SumW = $clog2(HISTORY_DEPTH * pbr_pkg::RATE_MAX + 1);

	// Rounded-up reciprocal of the depth; with this many fraction bits the
	// product gives the exact floor of sum / depth for every possible sum.
	localparam int MeanK  = SumW + $clog2(HISTORY_DEPTH);
	localparam int MeanRW = MeanK + 1;
	localparam int ProdW  = SumW + MeanRW;
	localparam logic [MeanRW-1:0] MEAN_RECIP =
		MeanRW'(((longint'(1) << MeanK) + longint'(HISTORY_DEPTH) - longint'(1))
		/ longint'(HISTORY_DEPTH));

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_RDIV = 3'd2;
	localparam logic [2:0] S_HWR  = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;

	logic [2:0] state_q;

	// Configuration.
	logic [SW-1:0] hyst_q;
	logic [CW-1:0] min_int_q;
	logic [CW-1:0] no_fing_q;
	logic [CW-1:0] inact_q;

	// Captured item.
	logic          smp_restart_q;
	logic [SW-1:0] smp_val_q;
	logic [TW-1:0] smp_time_q;

	// Detector state.
	logic          phase_q;
	logic [SW-1:0] peak_q;
	logic [SW-1:0] trough_q;
	logic [TW-1:0] peak_time_q;
	logic [TW-1:0] last_beat_q;
	logic [SW-1:0] hi_thr_q;
	logic [SW-1:0] lo_thr_q;
	logic          finger_q;
	logic [RW-1:0] last_rate_q;
	logic          beat_q;
	logic          rise_q;

	// Result register.
	logic          out_valid_q;
	logic          out_beat_q;
	logic          out_rise_q;
	logic          out_phase_q;
	logic [RW-1:0] out_irate_q;
	logic [RW-1:0] out_arate_q;
	logic          out_finger_q;
	logic          out_inact_q;

	pbr_pkg::div_req_t  div_req;
	pbr_pkg::div_rsp_t  div_rsp;
	pbr_pkg::hist_cmd_t hist_cmd;
	logic [SumW-1:0]    hist_sum;

	logic [SW-1:0]    swing;
	logic [TW-1:0]    interval;
	logic             up_peak;
	logic             drop;
	logic             down_trough;
	logic             climb;
	logic             accept_peak;
	logic             eval_beat;
	logic             eval_rise;
	logic [RW-1:0]    rate_sat;
	logic [TW-1:0]    since_beat;
	logic             finger_lost;
	logic             out_free;
	logic             out_load;
	logic [ProdW-1:0] mean_prod;

	assign swing       = (peak_q >= trough_q) ? (peak_q - trough_q) : '0;
	assign interval    = peak_time_q - last_beat_q;
	assign up_peak     = (smp_val_q > peak_q);
	assign drop        = (({1'b0, smp_val_q} + {1'b0, hyst_q}) < {1'b0, peak_q});
	assign down_trough = (smp_val_q < trough_q);
	assign climb       = ({1'b0, smp_val_q} > ({1'b0, trough_q} + {1'b0, hyst_q}));
	assign accept_peak = (interval > TW'(min_int_q)) && (swing > hi_thr_q);
	assign eval_beat   = !smp_restart_q && phase_q && !up_peak && drop && accept_peak;
	assign eval_rise   = !smp_restart_q && !phase_q && !down_trough && climb
		&& (swing > lo_thr_q);

	assign rate_sat = (|div_rsp.quotient[DW-1:RW]) ? RW'(pbr_pkg::RATE_MAX)
		: div_rsp.quotient[RW-1:0];

	assign since_beat  = smp_time_q - last_beat_q;
	assign finger_lost = (since_beat > TW'(no_fing_q)) && finger_q && (smp_val_q != '0);
	assign out_free    = !out_valid_q || result_out.ready;
	assign out_load    = (state_q == S_CHK) && out_free;
	assign mean_prod   = ProdW'(hist_sum) * ProdW'(MEAN_RECIP);

	always_comb begin
		div_req.start    = (state_q == S_EVAL) && eval_beat;
		div_req.dividend = pbr_pkg::RATE_NUM;
		div_req.divisor  = interval;
	end

	always_comb begin
		hist_cmd.clear = (state_q == S_EVAL) && smp_restart_q;
		hist_cmd.write = (state_q == S_HWR);
		hist_cmd.fill  = !finger_q;
		hist_cmd.rate  = rate_sat;
	end

	pbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pbr_history #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hist_cmd),
		.sum    (hist_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q    <= pbr_pkg::HYST_RST;
			min_int_q <= pbr_pkg::MIN_INT_RST;
			no_fing_q <= pbr_pkg::NO_FING_RST;
			inact_q   <= pbr_pkg::INACT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbr_pkg::REG_HYST:    hyst_q    <= cfg_wdata[SW-1:0];
				pbr_pkg::REG_MIN_INT: min_int_q <= cfg_wdata;
				pbr_pkg::REG_NO_FING: no_fing_q <= cfg_wdata;
				pbr_pkg::REG_INACT:   inact_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && sample_in.valid) begin
			smp_restart_q <= sample_in.restart;
			smp_val_q     <= sample_in.sample_value;
			smp_time_q    <= sample_in.sample_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= 1'b1;
			peak_q       <= '0;
			trough_q     <= '0;
			peak_time_q  <= '0;
			last_beat_q  <= '0;
			hi_thr_q     <= '0;
			lo_thr_q     <= '0;
			finger_q     <= 1'b1;
			last_rate_q  <= '0;
			beat_q       <= 1'b0;
			rise_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_beat_q   <= 1'b0;
			out_rise_q   <= 1'b0;
			out_phase_q  <= 1'b1;
			out_irate_q  <= '0;
			out_arate_q  <= '0;
			out_finger_q <= 1'b1;
			out_inact_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample_in.valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					beat_q  <= eval_beat;
					rise_q  <= eval_rise;
					state_q <= eval_beat ? S_RDIV : S_CHK;
					if (smp_restart_q) begin
						finger_q    <= 1'b0;
						last_beat_q <= smp_time_q;
						hi_thr_q    <= '0;
						lo_thr_q    <= '0;
					end else if (phase_q) begin
						if (up_peak) begin
							peak_q      <= smp_val_q;
							peak_time_q <= smp_time_q;
						end else if (drop) begin
							hi_thr_q <= pbr_pkg::swing_thr(swing);
							if (accept_peak) begin
								phase_q     <= 1'b0;
								trough_q    <= smp_val_q;
								last_beat_q <= peak_time_q;
							end else begin
								peak_time_q <= smp_time_q;
							end
						end
					end else begin
						if (down_trough) begin
							trough_q <= smp_val_q;
						end else if (climb) begin
							lo_thr_q <= pbr_pkg::swing_thr(swing);
							if (swing > lo_thr_q) begin
								phase_q <= 1'b1;
								peak_q  <= smp_val_q;
							end
						end
					end
				end
				S_RDIV: begin
					if (div_rsp.done) begin
						state_q <= S_HWR;
					end
				end
				S_HWR: begin
					// The history sees the old finger state to decide on a fill.
					last_rate_q <= rate_sat;
					finger_q    <= 1'b1;
					state_q     <= S_CHK;
				end
				S_CHK: begin
					if (out_free) begin
						out_beat_q   <= beat_q;
						out_rise_q   <= rise_q;
						out_phase_q  <= phase_q;
						out_irate_q  <= last_rate_q;
						out_arate_q  <= mean_prod[MeanK +: RW];
						out_finger_q <= finger_q && (smp_restart_q || !finger_lost);
						out_inact_q  <= !smp_restart_q && (since_beat > TW'(inact_q));
						if (!smp_restart_q && finger_lost) begin
							finger_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign sample_in.ready = (state_q == S_IDLE);

	assign result_out.valid          = out_valid_q;
	assign result_out.beat           = out_beat_q;
	assign result_out.rise           = out_rise_q;
	assign result_out.phase_rising   = out_phase_q;
	assign result_out.instant_rate   = out_irate_q;
	assign result_out.average_rate   = out_arate_q;
	assign result_out.finger_present = out_finger_q;
	assign result_out.inactive       = out_inact_q;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks pulse_beat_rate_detector_core against a cycle-free predictor of the
// hysteresis beat tracker. A short directed sequence covers the corner cases.
// Then synthetic pulse waveforms, noise, restarts and time jumps run under
// several register settings, including the extremes. Random gaps and stalls
// are applied on both channels.
// ----------------------------------------------------------------------------
module testbench;

	import pbr_pkg::*;

	localparam int DEPTH       = HISTORY_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE      = 60;

	typedef struct packed {
		logic              beat;
		logic              rise;
		logic              phase_rising;
		logic [RATE_W-1:0] instant_rate;
		logic [RATE_W-1:0] average_rate;
		logic              finger_present;
		logic              inactive;
	} beat_report_t;

	class pulse_scoreboard;
		int unsigned hyst, min_gap_ms, finger_timeout_ms, idle_timeout_ms;
		bit          rising;
		int unsigned peak_lvl, trough_lvl, peak_ms, beat_ms;
		int unsigned high_swing_prev, low_swing_prev;
		bit          finger_on;
		int unsigned rates[DEPTH];
		int unsigned rate_idx, latest_rate;
		beat_report_t expected_reports[$];
		int errors;

		function new();
			hyst = HYST_RST;
			min_gap_ms = MIN_INT_RST;
			finger_timeout_ms = NO_FING_RST;
			idle_timeout_ms = INACT_RST;
			rising = 1'b1;
			peak_lvl = 0;
			trough_lvl = 0;
			peak_ms = 0;
			beat_ms = 0;
			high_swing_prev = 0;
			low_swing_prev = 0;
			finger_on = 1'b1;
			foreach (rates[i]) rates[i] = 0;
			rate_idx = 0;
			latest_rate = 0;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_HYST:    hyst = data[SAMPLE_W-1:0];
				REG_MIN_INT: min_gap_ms = data;
				REG_NO_FING: finger_timeout_ms = data;
				REG_INACT:   idle_timeout_ms = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// Advances the tracker by one accepted item and queues its report.
		function void note_sample(bit restart, int unsigned v, int unsigned now);
			beat_report_t r;
			int unsigned swing, gap_ms, rate, sum;
			bit b, ri, idle;
			b = 0;
			ri = 0;
			idle = 0;
			if (restart) begin
				finger_on = 0;
				beat_ms = now;
				high_swing_prev = 0;
				low_swing_prev = 0;
				foreach (rates[i]) rates[i] = 0;
				rate_idx = 0;
			end else begin
				swing = (peak_lvl >= trough_lvl) ? peak_lvl - trough_lvl : 0;
				if (rising) begin
					if (v > peak_lvl) begin
						peak_lvl = v;
						peak_ms = now;
					end else if (v + hyst < peak_lvl) begin
						gap_ms = peak_ms - beat_ms;
						if (gap_ms > min_gap_ms && swing > high_swing_prev * 4 / 5) begin
							rate = 60000 / gap_ms;
							if (rate > RATE_MAX) rate = RATE_MAX;
							rising = 0;
							b = 1;
							if (!finger_on) begin
								foreach (rates[i]) rates[i] = rate;
							end else if (rate_idx < DEPTH) begin
								rates[rate_idx] = rate;
							end
							rate_idx++;
							if (rate_idx >= DEPTH) rate_idx = 0;
							latest_rate = rate;
							finger_on = 1;
							trough_lvl = v;
							beat_ms = peak_ms;
						end else begin
							peak_ms = now;
						end
						high_swing_prev = swing & 10'h3FF;
					end
				end else begin
					if (v < trough_lvl) begin
						trough_lvl = v;
					end else if (v > trough_lvl + hyst) begin
						if (swing > low_swing_prev * 4 / 5) begin
							rising = 1;
							ri = 1;
							peak_lvl = v;
						end
						low_swing_prev = swing & 10'h3FF;
					end
				end
				if (now - beat_ms > finger_timeout_ms && finger_on && v != 0) finger_on = 0;
				if (now - beat_ms > idle_timeout_ms) idle = 1;
			end
			sum = 0;
			foreach (rates[i]) sum += rates[i];
			r.beat = b;
			r.rise = ri;
			r.phase_rising = rising;
			r.instant_rate = latest_rate[RATE_W-1:0];
			r.average_rate = RATE_W'(sum / DEPTH);
			r.finger_present = finger_on;
			r.inactive = idle;
			expected_reports.push_back(r);
		endfunction

		function void compare_field(string name, logic [RATE_W-1:0] want, logic [RATE_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_report(beat_report_t got);
			beat_report_t want;
			if (expected_reports.size() == 0) begin
				$display("%0t: result item with no expectation waiting: %p", $time, got);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			compare_field("beat", want.beat, got.beat);
			compare_field("rise", want.rise, got.rise);
			compare_field("phase_rising", want.phase_rising, got.phase_rising);
			compare_field("instant_rate", want.instant_rate, got.instant_rate);
			compare_field("average_rate", want.average_rate, got.average_rate);
			compare_field("finger_present", want.finger_present, got.finger_present);
			compare_field("inactive", want.inactive, got.inactive);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pbr_in_if  sample_ch();
	pbr_out_if report_ch();

	pulse_beat_rate_detector_core #(
		.HISTORY_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample_in(sample_ch),
		.result_out(report_ch)
	);

	pulse_scoreboard sb = new();

	int unsigned clock_ms;
	int unsigned sent_items;
	int          pulse_amp;
	bit          steady_src;
	int          cycle_count;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && report_ch.valid && report_ch.ready)
			sb.check_report('{
				beat: report_ch.beat,
				rise: report_ch.rise,
				phase_rising: report_ch.phase_rising,
				instant_rate: report_ch.instant_rate,
				average_rate: report_ch.average_rate,
				finger_present: report_ch.finger_present,
				inactive: report_ch.inactive
			});
	end

	// Mostly short gaps, a few long ones, none while a steady stretch is on.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady_src || r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(16, 60);
	endfunction

	function automatic int clamp_sample(int v);
		if (v < 0) return 0;
		if (v > 1023) return 1023;
		return v;
	endfunction

	task automatic send_sample(bit restart, int unsigned v, int unsigned t);
		int n;
		n = idle_len();
		@(negedge clk);
		while (n > 0) begin
			sample_ch.valid = 1'b0;
			n--;
			@(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.restart = restart;
		sample_ch.sample_value = v[SAMPLE_W-1:0];
		sample_ch.sample_time = t;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(restart, v, t);
		sent_items++;
	endtask

	task automatic send_after(bit restart, int v, int unsigned dt);
		clock_ms += dt;
		send_sample(restart, clamp_sample(v), clock_ms);
	endtask

	task automatic drain();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int h, int m, int f, int i);
		drain();
		write_reg(REG_HYST, CFG_DATA_W'(h));
		write_reg(REG_MIN_INT, CFG_DATA_W'(m));
		write_reg(REG_NO_FING, CFG_DATA_W'(f));
		write_reg(REG_INACT, CFG_DATA_W'(i));
	endtask

	// One synthetic heartbeat: a ramp up to a peak and back down, with jitter.
	task automatic play_pulse(int dt_lo, int dt_hi);
		int base, top, up_n, dn_n, jit, k;
		base = $urandom_range(0, 250);
		if ($urandom_range(0, 4) == 0) pulse_amp = $urandom_range(0, 1023);
		else pulse_amp = pulse_amp * int'($urandom_range(90, 115)) / 100;
		if (pulse_amp > 1023) pulse_amp = 1023;
		top = base + pulse_amp;
		if (top > 1023) top = 1023;
		up_n = $urandom_range(3, 10);
		dn_n = $urandom_range(4, 16);
		jit = $urandom_range(0, 6);
		steady_src = ($urandom_range(0, 3) == 0);
		for (k = 1; k <= up_n; k++)
			send_after(0, base + (top - base) * k / up_n + int'($urandom_range(0, 2 * jit)) - jit,
				$urandom_range(dt_lo, dt_hi));
		for (k = 1; k <= dn_n; k++)
			send_after(0, top - (top - base) * k / dn_n + int'($urandom_range(0, 2 * jit)) - jit,
				$urandom_range(dt_lo, dt_hi));
	endtask

	task automatic run_phase(int n, int dt_lo, int dt_hi);
		int unsigned target;
		int r, k;
		target = sent_items + n;
		while (sent_items < target) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				play_pulse(dt_lo, dt_hi);
			end else if (r < 85) begin
				steady_src = 0;
				for (k = $urandom_range(1, 8); k > 0; k--)
					send_after(0, $urandom_range(0, 1023), $urandom_range(0, 3 * dt_hi));
			end else if (r < 90) begin
				send_after(1, $urandom_range(0, 1023), $urandom_range(0, dt_hi));
			end else if (r < 95) begin
				send_after(0, $urandom_range(0, 1023), $urandom_range(1000, 70000));
			end else if (r < 97) begin
				send_after(0, $urandom_range(0, 1023), $urandom);
			end else begin
				drain();
			end
		end
	endtask

	initial begin
		report_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 4) == 0) begin
				@(negedge clk);
				report_ch.ready = 1'b1;
				repeat ($urandom_range(20, 200)) @(negedge clk);
			end else begin
				repeat (idle_len()) begin
					@(negedge clk);
					report_ch.ready = 1'b0;
				end
				@(negedge clk);
				report_ch.ready = 1'b1;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.restart = 1'b0;
		sample_ch.sample_value = '0;
		sample_ch.sample_time = '0;
		cycle_count = 0;
		sent_items = 0;
		pulse_amp = 600;
		steady_src = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset settings.
		send_sample(0, 0, 0);
		send_sample(0, 1023, 100);
		// Peaks too soon after the last beat are rejected.
		send_sample(0, 500, 200);
		send_sample(0, 800, 600);
		send_sample(0, 700, 700);
		send_sample(0, 300, 720);
		send_sample(0, 0, 740);
		send_sample(0, 150, 760);
		send_sample(0, 1023, 800);
		send_sample(0, 1023, 820);
		send_sample(0, 600, 1200);
		send_sample(0, 400, 1300);
		// This trough swing is too small against the previous one.
		send_sample(0, 900, 1350);
		send_sample(0, 1, 1400);
		send_sample(0, 1023, 1450);
		send_sample(0, 1000, 4000);
		send_sample(0, 0, 5000);
		send_sample(0, 5, 20000);
		send_sample(1, 1023, 32'hFFFF_FF00);
		send_sample(0, 1023, 32'hFFFF_FFFF);
		// The first beat after a restart fills the whole history.
		send_sample(0, 300, 32'h0000_0200);
		send_sample(0, 2, 32'h0000_0220);
		send_sample(0, 800, 32'h0000_0240);
		// A zero sample never drops the finger.
		send_sample(0, 0, 32'h0000_1600);
		send_sample(0, 1, 32'h0000_1700);
		clock_ms = 32'h0000_1700;

		run_phase(250, 5, 30);
		configure(0, 0, 0, 0);
		run_phase(300, 1, 3);
		configure(1023, 65535, 65535, 65535);
		run_phase(120, 5, 40);
		configure(20, 150, 1500, 4000);
		run_phase(300, 2, 20);
		configure($urandom_range(5, 200), $urandom_range(0, 600), $urandom_range(500, 5000),
			$urandom_range(5000, 20000));
		run_phase(300, 2, 25);
		configure($urandom_range(0, 1023), $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535));
		run_phase(300, 1, 40);
		configure(100, 0, 65535, 0);
		run_phase(300, 1, 4);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0t: %0d errors, %0d results missing", $time, sb.errors, sb.pending());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
